// ===== design/sdi_pkg.sv =====
// Shared types, constants and helper functions for the SD card SPI-mode start-up sequencer.
// Used by sdi_csd_decode and sd_spi_card_init_sequencer; depends on nothing else.
package sdi_pkg;

    localparam int CAP_W = 42;

    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] CMD_PREFIX  = 8'h40;
    localparam logic [7:0] CRC_CMD0    = 8'h95;
    localparam logic [7:0] CRC_CMD8    = 8'h87;
    localparam logic [7:0] CRC_DEFAULT = 8'h01;
    localparam logic [7:0] DATA_TOKEN  = 8'hFE;
    localparam logic [7:0] BUSY_POLLS  = 8'd10;
    localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS    = 32'h4000_0000;

    localparam logic [7:0] RST_POLL_LIMIT = 8'd100;
    localparam logic [7:0] RST_TOKEN_MS   = 8'd100;
    localparam logic [7:0] RST_DUMMY      = 8'd80;
    localparam logic [7:0] RST_TRIES      = 8'd20;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_XFER  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [7:0] {
        REG_POLL_LIMIT = 8'd0,
        REG_TOKEN_MS   = 8'd1,
        REG_DUMMY      = 8'd2,
        REG_TRIES      = 8'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_BUSY         = 3'd0,
        ST_READY        = 3'd1,
        ST_CMD0_BAD     = 3'd2,
        ST_CMD55_SILENT = 3'd3,
        ST_CMD41_SILENT = 3'd4,
        ST_POLL_TIMEOUT = 3'd5,
        ST_CMD58_BAD    = 3'd6
    } status_t;

    // Card command numbers as they appear in the command byte.
    typedef enum logic [5:0] {
        CMD0  = 6'd0,
        CMD8  = 6'd8,
        CMD9  = 6'd9,
        CMD41 = 6'd41,
        CMD55 = 6'd55,
        CMD58 = 6'd58
    } card_cmd_t;

    function automatic logic [7:0] tries_for(input card_cmd_t c, input logic [7:0] tries);
        logic [7:0] r;
        r = ((c == CMD0) || (c == CMD8) || (c == CMD58)) ? tries : BUSY_POLLS;
        return r;
    endfunction

    // Byte k (0..5) of the six-byte command frame.
    function automatic logic [7:0] packet_byte(input card_cmd_t c, input logic v2,
                                               input logic [2:0] k);
        logic [31:0] arg;
        logic [7:0]  r;
        arg = '0;
        if (c == CMD8)
            arg = ARG_CMD8;
        if ((c == CMD41) && v2)
            arg = ARG_HCS;
        unique case (k)
            3'd0: r = CMD_PREFIX | {2'b00, c};
            3'd1: r = arg[31:24];
            3'd2: r = arg[23:16];
            3'd3: r = arg[15:8];
            3'd4: r = arg[7:0];
            3'd5: r = (c == CMD0) ? CRC_CMD0 : ((c == CMD8) ? CRC_CMD8 : CRC_DEFAULT);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/sdi_csd_decode.sv =====
// CSD register decoder: turns the sixteen CSD bytes into a card capacity in bytes.
// Depends on sdi_pkg for the capacity width.
module sdi_csd_decode
    import sdi_pkg::*;
(
    input  logic [15:0][7:0]   csd,
    output logic [CAP_W-1:0]   capacity
);

    logic [21:0]      c_size_v2;
    logic [11:0]      c_size_v1;
    logic [2:0]       c_mult;
    logic [4:0]       shift_v1;
    logic [CAP_W-1:0] blocks_v2;
    logic [CAP_W-1:0] blocks_v1;

    always_comb
    begin
        c_size_v2 = {csd[7][5:0], csd[8], csd[9]};
        c_size_v1 = {csd[6][1:0], csd[7], csd[8][7:6]};
        c_mult    = {csd[9][1:0], csd[10][7]};
        shift_v1  = {2'b00, c_mult} + 5'd11;
        blocks_v2 = {{(CAP_W-22){1'b0}}, c_size_v2} + {{(CAP_W-1){1'b0}}, 1'b1};
        blocks_v1 = {{(CAP_W-12){1'b0}}, c_size_v1} + {{(CAP_W-1){1'b0}}, 1'b1};
        // Version 2 counts 512 KiB units; anything else is read as version 1.
        if (csd[0][7:6] == 2'b01)
            capacity = blocks_v2 << 19;
        else
            capacity = blocks_v1 << shift_v1;
    end

endmodule

// ===== design/sd_spi_card_init_sequencer.sv =====
// Top level of the SD card SPI-mode start-up sequencer.
// Depends on sdi_pkg and sdi_csd_decode.
// Path: an accepted item moves from the input register to the result register, and waits in
// the input register while the result register is full and not being drained.
// Throughput: one item per cycle while the result stream is not stalled; each item is worked
// through combinationally between the input register and the result register.
// Reset: asynchronous, active low; sequencer idle, select high, slow clock, status busy,
// configuration registers at their documented defaults.
module sd_spi_card_init_sequencer
    import sdi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] tx_byte, [8] tx_request, [9] select_low, [10] fast_clock, [13:11] status,
    // [14] card_v2, [15] block_addressed, [57:16] size_bytes, [63:58] zero
    output logic [63:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_DUMMY, PH_PRE, PH_PKT, PH_POLL, PH_FLUSH, PH_END1, PH_END2,
        PH_R7, PH_OCR, PH_TOKEN, PH_CSD, PH_CRC, PH_DELAY, PH_DONE
    } phase_t;

    // Configuration registers.
    logic [7:0] poll_limit_reg, token_ms_reg, dummy_reg, tries_reg;

    // Input register.
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [7:0] in_rx_reg;

    // Sequencer state.
    phase_t     phase_reg, phase_next;
    card_cmd_t  cmd_reg, cmd_next;
    logic [7:0] bc_reg, bc_next, ac_reg, ac_next, ms_reg, ms_next, r1_reg, r1_next;
    logic       v2_reg, v2_next, hc_reg, hc_next, sel_reg, sel_next;
    logic       fast_reg, fast_next, ok_reg, ok_next;
    logic [2:0] stat_reg, stat_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [3:0][7:0]  trailer_reg;
    logic [15:0][7:0] csd_reg;
    logic       tr_we, csd_we;

    // Result register.
    logic       out_valid_reg;
    logic [63:0] out_data_reg;
    logic [7:0] tx_next;
    logic       req_next;

    logic       fire;
    logic [CAP_W-1:0] csd_capacity;
    logic [7:0] bc_inc, ac_inc, ms_dec;

    sdi_csd_decode u_csd_decode
    (
        .csd      (csd_reg),
        .capacity (csd_capacity)
    );

    // A new item moves on whenever the result register is free or being drained.
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign bc_inc = bc_reg + 8'd1;
    assign ac_inc = ac_reg + 8'd1;
    assign ms_dec = (ms_reg != 8'd0) ? ms_reg - 8'd1 : ms_reg;

    // One step of the sequence for the item held in the input register.
    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        bc_next    = bc_reg;
        ac_next    = ac_reg;
        ms_next    = ms_reg;
        r1_next    = r1_reg;
        v2_next    = v2_reg;
        hc_next    = hc_reg;
        sel_next   = sel_reg;
        fast_next  = fast_reg;
        ok_next    = ok_reg;
        stat_next  = stat_reg;
        cap_next   = cap_reg;
        tx_next    = 8'h00;
        req_next   = 1'b0;
        tr_we      = 1'b0;
        csd_we     = 1'b0;

        unique case (in_cmd_reg)
            REQ_START:
            begin
                sel_next = 1'b0; fast_next = 1'b0; v2_next = 1'b0; hc_next = 1'b0;
                ok_next = 1'b0; cap_next = '0; r1_next = IDLE_BYTE; ac_next = '0;
                ms_next = '0; stat_next = ST_BUSY; bc_next = '0;
                tx_next = IDLE_BYTE; req_next = 1'b1;
                if (dummy_reg != 8'd0)
                    phase_next = PH_DUMMY;
                else
                begin
                    cmd_next = CMD0; sel_next = 1'b1; phase_next = PH_PRE;
                end
            end
            REQ_XFER:
            begin
                unique case (phase_reg)
                    PH_DUMMY:
                    begin
                        bc_next = bc_inc; tx_next = IDLE_BYTE; req_next = 1'b1;
                        if (bc_inc >= dummy_reg)
                        begin
                            cmd_next = CMD0; sel_next = 1'b1; phase_next = PH_PRE;
                        end
                    end
                    PH_PRE:
                    begin
                        phase_next = PH_PKT; bc_next = '0; req_next = 1'b1;
                        tx_next = packet_byte(cmd_reg, v2_reg, 3'd0);
                    end
                    PH_PKT:
                    begin
                        bc_next = bc_inc; req_next = 1'b1; tx_next = IDLE_BYTE;
                        if (bc_inc < 8'd6)
                            tx_next = packet_byte(cmd_reg, v2_reg, bc_inc[2:0]);
                        else if (tries_for(cmd_reg, tries_reg) == 8'd0)
                        begin
                            sel_next = 1'b0; phase_next = PH_FLUSH;
                        end
                        else
                        begin
                            phase_next = PH_POLL; bc_next = '0;
                        end
                    end
                    PH_POLL:
                    begin
                        bc_next = bc_inc;
                        if (!in_rx_reg[7])
                        begin
                            r1_next = in_rx_reg;
                            // Handling of a valid R1 depends on the command.
                            unique case (cmd_reg)
                                CMD0:
                                begin
                                    if (in_rx_reg == 8'h01)
                                    begin
                                        phase_next = PH_END1; tx_next = IDLE_BYTE;
                                        req_next = 1'b1;
                                    end
                                    else
                                    begin
                                        stat_next = ST_CMD0_BAD; phase_next = PH_DONE;
                                    end
                                end
                                CMD8:
                                begin
                                    tx_next = IDLE_BYTE; req_next = 1'b1;
                                    if (in_rx_reg == 8'h01)
                                    begin
                                        phase_next = PH_R7; bc_next = '0;
                                    end
                                    else
                                        phase_next = PH_END1;
                                end
                                CMD58:
                                begin
                                    if (in_rx_reg == 8'h00)
                                    begin
                                        phase_next = PH_OCR; bc_next = '0;
                                        tx_next = IDLE_BYTE; req_next = 1'b1;
                                    end
                                    else
                                    begin
                                        stat_next = ST_CMD58_BAD; phase_next = PH_DONE;
                                    end
                                end
                                CMD9:
                                begin
                                    tx_next = IDLE_BYTE; req_next = 1'b1;
                                    if (in_rx_reg == 8'h00)
                                    begin
                                        phase_next = PH_TOKEN; ms_next = '0;
                                    end
                                    else
                                        phase_next = PH_END1;
                                end
                                default:
                                begin
                                    phase_next = PH_END1; tx_next = IDLE_BYTE;
                                    req_next = 1'b1;
                                end
                            endcase
                        end
                        else
                        begin
                            tx_next = IDLE_BYTE; req_next = 1'b1;
                            if (bc_inc >= tries_for(cmd_reg, tries_reg))
                            begin
                                sel_next = 1'b0; phase_next = PH_FLUSH;
                            end
                        end
                    end
                    PH_FLUSH:
                    begin
                        // The command stayed silent.
                        unique case (cmd_reg)
                            CMD0:
                            begin
                                stat_next = ST_CMD0_BAD; phase_next = PH_DONE;
                            end
                            CMD8:
                            begin
                                ac_next = '0;
                                if (poll_limit_reg != 8'd0)
                                begin
                                    cmd_next = CMD55; sel_next = 1'b1; phase_next = PH_PRE;
                                    tx_next = IDLE_BYTE; req_next = 1'b1;
                                end
                                else
                                begin
                                    stat_next = ST_POLL_TIMEOUT; phase_next = PH_DONE;
                                end
                            end
                            CMD55:
                            begin
                                stat_next = ST_CMD55_SILENT; phase_next = PH_DONE;
                            end
                            CMD41:
                            begin
                                stat_next = ST_CMD41_SILENT; phase_next = PH_DONE;
                            end
                            CMD58:
                            begin
                                stat_next = ST_CMD58_BAD; phase_next = PH_DONE;
                            end
                            default:
                            begin
                                phase_next = PH_END1; tx_next = IDLE_BYTE; req_next = 1'b1;
                            end
                        endcase
                    end
                    PH_END1:
                    begin
                        sel_next = 1'b0; phase_next = PH_END2;
                        tx_next = IDLE_BYTE; req_next = 1'b1;
                    end
                    PH_END2:
                    begin
                        unique case (cmd_reg)
                            CMD0:
                            begin
                                ms_next = 8'd2; phase_next = PH_DELAY;
                            end
                            CMD8:
                            begin
                                ac_next = '0;
                                if (poll_limit_reg != 8'd0)
                                begin
                                    cmd_next = CMD55; sel_next = 1'b1; phase_next = PH_PRE;
                                    tx_next = IDLE_BYTE; req_next = 1'b1;
                                end
                                else
                                begin
                                    stat_next = ST_POLL_TIMEOUT; phase_next = PH_DONE;
                                end
                            end
                            CMD55:
                            begin
                                cmd_next = CMD41; sel_next = 1'b1; phase_next = PH_PRE;
                                tx_next = IDLE_BYTE; req_next = 1'b1;
                            end
                            CMD41:
                            begin
                                if (r1_reg == 8'h00)
                                begin
                                    cmd_next = CMD58; sel_next = 1'b1; phase_next = PH_PRE;
                                    tx_next = IDLE_BYTE; req_next = 1'b1;
                                end
                                else
                                begin
                                    ms_next = 8'd1; phase_next = PH_DELAY;
                                end
                            end
                            CMD58:
                            begin
                                fast_next = 1'b1; cmd_next = CMD9; sel_next = 1'b1;
                                phase_next = PH_PRE; tx_next = IDLE_BYTE; req_next = 1'b1;
                            end
                            default:
                            begin
                                if (ok_reg)
                                    cap_next = csd_capacity;
                                stat_next = ST_READY; phase_next = PH_DONE;
                            end
                        endcase
                    end
                    PH_R7, PH_OCR:
                    begin
                        tr_we = 1'b1; bc_next = bc_inc;
                        tx_next = IDLE_BYTE; req_next = 1'b1;
                        if (bc_inc >= 8'd4)
                        begin
                            // The byte in flight is the last trailer byte.
                            if (phase_reg == PH_R7)
                                v2_next = (trailer_reg[2] == 8'h01) && (in_rx_reg == 8'hAA);
                            else
                                hc_next = v2_reg && trailer_reg[0][6];
                            phase_next = PH_END1;
                        end
                    end
                    PH_TOKEN:
                    begin
                        tx_next = IDLE_BYTE; req_next = 1'b1;
                        if (in_rx_reg == DATA_TOKEN)
                        begin
                            phase_next = PH_CSD; bc_next = '0;
                        end
                        else if ((in_rx_reg[7:4] == 4'h0) || (ms_reg >= token_ms_reg))
                            phase_next = PH_END1;
                    end
                    PH_CSD:
                    begin
                        csd_we = 1'b1; bc_next = bc_inc;
                        tx_next = IDLE_BYTE; req_next = 1'b1;
                        if (bc_inc >= 8'd16)
                        begin
                            phase_next = PH_CRC; bc_next = '0;
                        end
                    end
                    PH_CRC:
                    begin
                        bc_next = bc_inc; tx_next = IDLE_BYTE; req_next = 1'b1;
                        if (bc_inc >= 8'd2)
                        begin
                            ok_next = 1'b1; phase_next = PH_END1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_TICK:
            begin
                if (phase_reg == PH_DELAY)
                begin
                    ms_next = ms_dec;
                    if (ms_dec == 8'd0)
                    begin
                        if (cmd_reg == CMD0)
                        begin
                            cmd_next = CMD8; sel_next = 1'b1; phase_next = PH_PRE;
                            tx_next = IDLE_BYTE; req_next = 1'b1;
                        end
                        else
                        begin
                            ac_next = ac_inc;
                            if (ac_inc < poll_limit_reg)
                            begin
                                cmd_next = CMD55; sel_next = 1'b1; phase_next = PH_PRE;
                                tx_next = IDLE_BYTE; req_next = 1'b1;
                            end
                            else
                            begin
                                stat_next = ST_POLL_TIMEOUT; phase_next = PH_DONE;
                            end
                        end
                    end
                end
                else if (phase_reg == PH_TOKEN)
                begin
                    if (ms_reg != 8'hFF)
                        ms_next = ms_reg + 8'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= RST_POLL_LIMIT;
            token_ms_reg   <= RST_TOKEN_MS;
            dummy_reg      <= RST_DUMMY;
            tries_reg      <= RST_TRIES;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            cmd_reg        <= CMD0;
            bc_reg         <= '0;
            ac_reg         <= '0;
            ms_reg         <= '0;
            r1_reg         <= IDLE_BYTE;
            v2_reg         <= 1'b0;
            hc_reg         <= 1'b0;
            sel_reg        <= 1'b0;
            fast_reg       <= 1'b0;
            ok_reg         <= 1'b0;
            stat_reg       <= ST_BUSY;
            cap_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_POLL_LIMIT: poll_limit_reg <= cfg_data;
                    REG_TOKEN_MS:   token_ms_reg   <= cfg_data;
                    REG_DUMMY:      dummy_reg      <= cfg_data;
                    REG_TRIES:      tries_reg      <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (fire)
            begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
                bc_reg    <= bc_next;
                ac_reg    <= ac_next;
                ms_reg    <= ms_next;
                r1_reg    <= r1_next;
                v2_reg    <= v2_next;
                hc_reg    <= hc_next;
                sel_reg   <= sel_next;
                fast_reg  <= fast_next;
                ok_reg    <= ok_next;
                stat_reg  <= stat_next;
                cap_reg   <= cap_next;
            end
        end
    end

    // Payload registers: input item, trailer and CSD bytes, and the result word.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg <= s_tuser;
            in_rx_reg  <= s_tdata;
        end
        if (fire && tr_we)
            trailer_reg[bc_reg[1:0]] <= in_rx_reg;
        if (fire && csd_we)
            csd_reg[bc_reg[3:0]] <= in_rx_reg;
        if (fire)
            out_data_reg <= {6'b0, cap_next, hc_next, v2_next, stat_next, fast_next,
                             sel_next, req_next, tx_next};
    end

endmodule
